// ===== src/lbe_pkg.sv =====
// shared types and constants of the lru budget evictor
package lbe_pkg;

	// field widths
	localparam int ID_W     = 16;
	localparam int TICK_W   = 48;
	localparam int SIZE_W   = 40;
	localparam int BYTES_W  = 48;
	localparam int LEVEL_W  = 14;
	localparam int AGE_W    = 32;
	localparam int TOTAL_W  = 45;
	localparam int COUNT_W  = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// byte count times level, and the fixed point scale of the levels
	localparam int PROD_W = BYTES_W + LEVEL_W;
	localparam logic [LEVEL_W-1:0] PCT_SCALE = LEVEL_W'(10000);

	// reset values of the configuration registers
	localparam logic [LEVEL_W-1:0] START_RST  = LEVEL_W'(9000);
	localparam logic [LEVEL_W-1:0] TARGET_RST = LEVEL_W'(7500);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_LEVEL  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LEVEL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_AGE      = 2'd2;

	// operation codes and result kinds
	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_COLLECT = 1'b1;
	localparam logic KIND_EVICT   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// one stored candidate
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TICK_W-1:0] tick;
		logic [SIZE_W-1:0] size;
	} lbe_entry_t;

	// strobes from the sequencer to the candidate store
	typedef struct packed {
		logic wr_en;
		logic clr_one;
		logic clr_all;
	} lbe_store_ctl_t;

	// collection sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_USED,
		ST_MUL_START,
		ST_MUL_TGT,
		ST_TGT,
		ST_PICK,
		ST_SCAN,
		ST_DECIDE,
		ST_ACC,
		ST_SUMMARY
	} lbe_state_t;

endpackage

// ===== src/lbe_cmd_if.sv =====
// input channel of the lru budget evictor
interface lbe_cmd_if;
	logic                          valid;
	logic                          ready;
	logic                          op;
	logic [lbe_pkg::ID_W-1:0]      cand_id;
	logic [lbe_pkg::TICK_W-1:0]    cand_last_used;
	logic [lbe_pkg::SIZE_W-1:0]    cand_size;
	logic                          cand_eligible;
	logic [lbe_pkg::BYTES_W-1:0]   used_bytes;
	logic [lbe_pkg::BYTES_W-1:0]   budget_bytes;
	logic [lbe_pkg::TICK_W-1:0]    now_tick;

	modport source (
		output valid, op, cand_id, cand_last_used, cand_size, cand_eligible,
		       used_bytes, budget_bytes, now_tick,
		input  ready
	);
	modport sink (
		input  valid, op, cand_id, cand_last_used, cand_size, cand_eligible,
		       used_bytes, budget_bytes, now_tick,
		output ready
	);
endinterface

// ===== src/lbe_rsp_if.sv =====
// result channel of the lru budget evictor
interface lbe_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic [lbe_pkg::ID_W-1:0]      evict_id;
	logic [lbe_pkg::SIZE_W-1:0]    evict_size;
	logic                          ran;
	logic [lbe_pkg::TOTAL_W-1:0]   total_freed;
	logic [lbe_pkg::COUNT_W-1:0]   count_freed;
	logic                          overflowed;
	logic                          last;

	modport source (
		output valid, kind, evict_id, evict_size, ran, total_freed, count_freed,
		       overflowed, last,
		input  ready
	);
	modport sink (
		input  valid, kind, evict_id, evict_size, ran, total_freed, count_freed,
		       overflowed, last,
		output ready
	);
endinterface

// ===== src/lbe_store.sv =====
// candidate store: entry memory with registered read and per-slot taken bits
module lbe_store #(
	parameter int Depth = 32,
	parameter int IdxW  = 5
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lbe_pkg::lbe_store_ctl_t ctl,
	input  logic [IdxW-1:0]         wr_addr,
	input  lbe_pkg::lbe_entry_t     wr_data,
	input  logic [IdxW-1:0]         clr_addr,
	input  logic [IdxW-1:0]         rd_addr,
	output lbe_pkg::lbe_entry_t     rd_data,
	output logic                    rd_taken
);
	import lbe_pkg::*;

	lbe_entry_t       mem [Depth];
	logic [Depth-1:0] taken_q;
	lbe_entry_t       rd_data_q;
	logic             rd_taken_q;

	// entry memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	// taken bits: set on load, cleared on eviction or at the end of a collection
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q    <= '0;
			rd_taken_q <= 1'b0;
		end else begin
			rd_taken_q <= taken_q[rd_addr];
			if (ctl.clr_all) begin
				taken_q <= '0;
			end else begin
				if (ctl.wr_en) begin
					taken_q[wr_addr] <= 1'b1;
				end
				if (ctl.clr_one) begin
					taken_q[clr_addr] <= 1'b0;
				end
			end
		end
	end

	assign rd_data  = rd_data_q;
	assign rd_taken = rd_taken_q;
endmodule

// ===== src/lbe_div.sv =====
// reclaim tracker: freed bytes against bytes wanted back, both in level-scaled form
module lbe_div (
	input  logic                       clk,
	input  logic                       load,
	input  logic                       add,
	input  logic [lbe_pkg::PROD_W-1:0] used_scaled,
	input  logic [lbe_pkg::PROD_W-1:0] prod,
	output logic                       enough
);
	import lbe_pkg::*;

	logic [PROD_W-1:0] want_q;
	logic [PROD_W-1:0] freed_q;

	// freed >= used - floor(budget * target / scale) holds exactly when
	// freed * scale >= used * scale - budget * target, so no divide is needed
	always_ff @(posedge clk) begin
		if (load) begin
			want_q  <= used_scaled - prod;
			freed_q <= '0;
		end else if (add) begin
			freed_q <= freed_q + prod;
		end
	end

	assign enough = (freed_q >= want_q);
endmodule

// ===== src/lru_budget_evictor.sv =====
// lru budget evictor: loads fill a candidate store, a collect evicts oldest first
// a load transfer leaves the block in idle, so it stays ready for the next command
// a collect first runs MUL_USED, MUL_START and MUL_TGT on the shared multiplier, then TGT;
// each eviction over the N loaded slots runs pick, the one-slot search, decide and sum,
// and setup or a last pick or search leads to summary; result stalls hold decide and summary
// reset empties the store, clears the overflow flag and loads the level defaults
module lru_budget_evictor #(
	parameter int MAX_CANDIDATES = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lbe_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [lbe_pkg::CFG_DATA_W-1:0] cfg_data,
	lbe_cmd_if.sink                       cmd,
	lbe_rsp_if.source                     rsp
);
	import lbe_pkg::*;

	localparam int IDX_W = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
	localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);
	localparam int FREED_W = TOTAL_W + 1;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_CANDIDATES);

	lbe_state_t state_q, state_d;

	// configuration registers
	logic [LEVEL_W-1:0] start_q, target_q;
	logic [AGE_W-1:0]   min_age_q;

	// collect operands and working registers
	logic [BYTES_W-1:0] used_q, budget_q;
	logic [TICK_W-1:0]  now_q;
	logic [PROD_W-1:0]  prod_q, usedx_q;
	logic [FREED_W-1:0] freed_q;
	logic [CNT_W-1:0]   evict_cnt_q;
	logic               ran_q;

	// store bookkeeping
	logic [CNT_W-1:0]   cnt_q;
	logic               ovf_q;
	logic [CNT_W-1:0]   scan_q;
	logic               cmp_vld_s1;
	logic [IDX_W-1:0]   cmp_slot_s1;
	logic               best_vld_q;
	logic [IDX_W-1:0]   best_idx_q;
	lbe_entry_t         best_q;

	// result register
	logic               out_vld_q;
	logic               out_kind_q, out_ran_q, out_ovf_q, out_last_q;
	logic [ID_W-1:0]    out_id_q;
	logic [SIZE_W-1:0]  out_size_q;
	logic [TOTAL_W-1:0] out_total_q;
	logic [COUNT_W-1:0] out_count_q;

	// control strobes
	logic               cmd_xfer, load_keep, out_free, issue, evict_go, sum_go;
	logic               trk_load, trk_add, tgt_over, enough;
	logic               run_ok, better, prot, future;
	lbe_store_ctl_t     store_ctl;
	lbe_entry_t         rd_entry, wr_entry;
	logic               rd_taken;
	logic [BYTES_W-1:0] mul_a;
	logic [LEVEL_W-1:0] mul_b;
	logic [TICK_W:0]    age;
	logic [TOTAL_W-1:0] total_sat;

	// candidate store and reclaim tracker
	lbe_store #(.Depth(MAX_CANDIDATES), .IdxW(IDX_W)) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (store_ctl),
		.wr_addr  (cnt_q[IDX_W-1:0]),
		.wr_data  (wr_entry),
		.clr_addr (best_idx_q),
		.rd_addr  (scan_q[IDX_W-1:0]),
		.rd_data  (rd_entry),
		.rd_taken (rd_taken)
	);

	lbe_div u_div (
		.clk         (clk),
		.load        (trk_load),
		.add         (trk_add),
		.used_scaled (usedx_q),
		.prod        (prod_q),
		.enough      (enough)
	);

	assign wr_entry = '{id: cmd.cand_id, tick: cmd.cand_last_used, size: cmd.cand_size};

	// datapath conditions
	assign out_free  = !out_vld_q || rsp.ready;
	assign load_keep = cmd.cand_eligible && (cmd.cand_size != '0);
	assign run_ok    = (budget_q != '0) && (usedx_q >= prod_q);
	assign tgt_over  = (usedx_q > prod_q);
	assign better    = !best_vld_q || (rd_entry.tick < best_q.tick) ||
	                   ((rd_entry.tick == best_q.tick) && (rd_entry.size > best_q.size));
	assign age       = {1'b0, now_q} - {1'b0, best_q.tick};
	assign future    = age[TICK_W];
	assign prot      = (best_q.tick != '0) && !future &&
	                   (age[TICK_W-1:0] < TICK_W'(min_age_q));
	assign total_sat = (freed_q > FREED_W'({TOTAL_W{1'b1}})) ? {TOTAL_W{1'b1}}
	                                                          : freed_q[TOTAL_W-1:0];

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			ST_MUL_USED: begin
				mul_a = used_q;
				mul_b = PCT_SCALE;
			end
			ST_MUL_START: begin
				mul_a = budget_q;
				mul_b = start_q;
			end
			ST_DECIDE: begin
				mul_a = BYTES_W'(best_q.size);
				mul_b = PCT_SCALE;
			end
			default: begin
				mul_a = budget_q;
				mul_b = target_q;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		cmd.ready     = (state_q == ST_IDLE);
		cmd_xfer      = cmd.valid && cmd.ready;
		issue         = (state_q == ST_SCAN) && (scan_q < cnt_q);
		trk_load      = (state_q == ST_TGT);
		trk_add       = (state_q == ST_ACC);
		evict_go      = (state_q == ST_DECIDE) && best_vld_q && !prot && out_free;
		sum_go        = (state_q == ST_SUMMARY) && out_free;
		store_ctl.wr_en   = cmd_xfer && (cmd.op == OP_LOAD) && load_keep && (cnt_q != FULL_CNT);
		store_ctl.clr_one = evict_go;
		store_ctl.clr_all = sum_go;
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_xfer && (cmd.op == OP_COLLECT)) state_d = ST_MUL_USED;
			end
			ST_MUL_USED:  state_d = ST_MUL_START;
			ST_MUL_START: state_d = ST_MUL_TGT;
			ST_MUL_TGT:   state_d = run_ok ? ST_TGT : ST_SUMMARY;
			ST_TGT:       state_d = tgt_over ? ST_PICK : ST_SUMMARY;
			ST_PICK:      state_d = enough ? ST_SUMMARY : ST_SCAN;
			ST_SCAN: begin
				if (!issue) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (!best_vld_q || prot) state_d = ST_SUMMARY;
				else if (out_free) state_d = ST_ACC;
			end
			ST_ACC:       state_d = ST_PICK;
			ST_SUMMARY: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			start_q    <= START_RST;
			target_q   <= TARGET_RST;
			min_age_q  <= '0;
			cnt_q      <= '0;
			ovf_q      <= 1'b0;
			out_vld_q  <= 1'b0;
			cmp_vld_s1 <= 1'b0;
			best_vld_q <= 1'b0;
			scan_q     <= '0;
		end else begin
			state_q    <= state_d;
			cmp_vld_s1 <= issue;

			// configuration writes
			if (cfg_we) begin
				case (cfg_idx)
					CFG_START_LEVEL:  start_q   <= cfg_data[LEVEL_W-1:0];
					CFG_TARGET_LEVEL: target_q  <= cfg_data[LEVEL_W-1:0];
					CFG_MIN_AGE:      min_age_q <= cfg_data[AGE_W-1:0];
					default: ;
				endcase
			end

			// store fill and overflow
			if (store_ctl.wr_en) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd_xfer && (cmd.op == OP_LOAD) && load_keep && (cnt_q == FULL_CNT)) begin
				ovf_q <= 1'b1;
			end
			if (sum_go) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end

			// minimum search over the store
			if (state_q == ST_PICK) begin
				scan_q     <= '0;
				best_vld_q <= 1'b0;
			end
			if (issue) begin
				scan_q <= scan_q + CNT_W'(1);
			end
			if (cmp_vld_s1 && rd_taken && better) begin
				best_vld_q <= 1'b1;
			end

			// result handshake
			if (evict_go || sum_go) out_vld_q <= 1'b1;
			else if (rsp.ready) out_vld_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		// collect operands
		if (cmd_xfer && (cmd.op == OP_COLLECT)) begin
			used_q      <= cmd.used_bytes;
			budget_q    <= cmd.budget_bytes;
			now_q       <= cmd.now_tick;
			freed_q     <= '0;
			evict_cnt_q <= '0;
			ran_q       <= 1'b0;
		end

		// shared multiplier, registered
		if ((state_q == ST_MUL_USED) || (state_q == ST_MUL_START) ||
		    (state_q == ST_MUL_TGT) || (state_q == ST_DECIDE)) begin
			prod_q <= mul_a * mul_b;
		end
		if (state_q == ST_MUL_START) usedx_q <= prod_q;
		if (state_q == ST_MUL_TGT) ran_q <= run_ok;

		// best candidate so far
		cmp_slot_s1 <= scan_q[IDX_W-1:0];
		if (cmp_vld_s1 && rd_taken && better) begin
			best_q     <= rd_entry;
			best_idx_q <= cmp_slot_s1;
		end

		// eviction result
		if (evict_go) begin
			freed_q     <= freed_q + FREED_W'(best_q.size);
			evict_cnt_q <= evict_cnt_q + CNT_W'(1);
			out_kind_q  <= KIND_EVICT;
			out_id_q    <= best_q.id;
			out_size_q  <= best_q.size;
			out_ran_q   <= 1'b1;
			out_total_q <= '0;
			out_count_q <= '0;
			out_ovf_q   <= 1'b0;
			out_last_q  <= 1'b0;
		end

		// summary result
		if (sum_go) begin
			out_kind_q  <= KIND_SUMMARY;
			out_id_q    <= '0;
			out_size_q  <= '0;
			out_ran_q   <= ran_q;
			out_total_q <= total_sat;
			out_count_q <= COUNT_W'(evict_cnt_q);
			out_ovf_q   <= ovf_q;
			out_last_q  <= 1'b1;
		end
	end

	// result channel
	assign rsp.valid       = out_vld_q;
	assign rsp.kind        = out_kind_q;
	assign rsp.evict_id    = out_id_q;
	assign rsp.evict_size  = out_size_q;
	assign rsp.ran         = out_ran_q;
	assign rsp.total_freed = out_total_q;
	assign rsp.count_freed = out_count_q;
	assign rsp.overflowed  = out_ovf_q;
	assign rsp.last        = out_last_q;
endmodule
